FILE: hdl/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue checker.
// Depends on nothing; included by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: hdl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// Depends on nothing; used by the cell, the top level and the checker.
package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int DATA_BITS     = 32;
   localparam int PRIORITY_BITS = 16;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_PUSH_FULL  = 2'd1,
      STATUS_POP_EMPTY  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] data;
      logic [PRIORITY_BITS-1:0]    prio;
   } entry_type;

   // Broadcast to every cell for one transaction.
   typedef struct packed {
      logic      push_ok;
      logic      pop_ok;
      entry_type new_entry;
   } cmd_type;

endpackage

FILE: hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and moves it to a neighbor.
// Depends on spq_pkg.
module spq_cell (
   input  logic               clock,
   input  logic               is_head,
   input  logic               occupied,
   input  spq_pkg::cmd_type   cmd,
   input  logic               left_insert,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               insert_here,
   output spq_pkg::entry_type entry,
   output spq_pkg::entry_type entry_next
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The head yields only to a strictly smaller value, the others to equal ones.
   always_comb begin
      if (!occupied) begin
         insert_here = 1'b1;
      end else if (is_head) begin
         insert_here = entry_ff.prio > cmd.new_entry.prio;
      end else begin
         insert_here = entry_ff.prio >= cmd.new_entry.prio;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push_ok && insert_here) begin
         entry_in = left_insert ? left_entry : cmd.new_entry;
      end else if (cmd.pop_ok) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

FILE: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of slot cells and the
// response register. Depends on spq_pkg and spq_cell.
//
//   Channel   Direction  Handshake             Payload
//   request   in         start high, busy low  req_kind, req_data_value,
//                                              req_priority_level
//   response  out        rsp_strobe, one cycle rsp_head_data .. rsp_status
//
// One transaction is taken every cycle. Its response is strobed in the cycle
// after acceptance, because each cell compares its priority with the new one
// and picks its next entry combinationally, so the whole chain shifts at once.
// Reset clears the entry count and the response strobe; the slot contents are
// left as they are, since only slots below the count are ever read.
// The block never stalls: busy stays low, and the receiver must take every
// response in the cycle it is shown; the block itself does not enforce this.
module sorted_priority_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_kind,
   input  logic signed [spq_pkg::DATA_BITS-1:0]   req_data_value,
   input  logic [spq_pkg::PRIORITY_BITS-1:0]      req_priority_level,
   output logic                                   rsp_strobe,
   output logic signed [spq_pkg::DATA_BITS-1:0]   rsp_head_data,
   output logic [spq_pkg::PRIORITY_BITS-1:0]      rsp_head_priority,
   output logic signed [spq_pkg::DATA_BITS-1:0]   rsp_popped_data,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_is_full,
   output logic [spq_pkg::COUNT_BITS-1:0]         rsp_entry_count,
   output logic [1:0]                             rsp_status
);
   import spq_pkg::*;

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   logic                  accept;
   logic                  is_full_now;
   logic                  is_empty_now;
   cmd_type               cmd;
   status_type            status_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   logic                  insert_here [CAPACITY];
   entry_type             entry       [CAPACITY];
   entry_type             entry_next  [CAPACITY];

   logic                        rsp_strobe_ff;
   logic signed [DATA_BITS-1:0] rsp_head_data_ff,     rsp_head_data_in;
   logic [PRIORITY_BITS-1:0]    rsp_head_priority_ff, rsp_head_priority_in;
   logic signed [DATA_BITS-1:0] rsp_popped_data_ff,   rsp_popped_data_in;
   logic [COUNT_BITS-1:0]       rsp_entry_count_ff;
   logic [1:0]                  rsp_status_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_full_now  = count_ff == FULL_COUNT;
   assign is_empty_now = count_ff == '0;

   // Decide the transaction: a push to a full queue or a pop from an empty
   // one leaves every cell untouched and only reports the rejection.
   always_comb begin
      cmd.push_ok        = 1'b0;
      cmd.pop_ok         = 1'b0;
      cmd.new_entry.data = req_data_value;
      cmd.new_entry.prio = req_priority_level;
      status_in          = STATUS_DONE;
      count_in           = count_ff;
      if (accept) begin
         if (req_kind == KIND_PUSH) begin
            if (is_full_now) begin
               status_in = STATUS_PUSH_FULL;
            end else begin
               cmd.push_ok = 1'b1;
               count_in    = count_ff + COUNT_BITS'(1);
            end
         end else begin
            if (is_empty_now) begin
               status_in = STATUS_POP_EMPTY;
            end else begin
               cmd.pop_ok = 1'b1;
               count_in   = count_ff - COUNT_BITS'(1);
            end
         end
      end
   end

   // The chain: cell zero is the head. A cell whose left neighbor also wants
   // the new entry takes that neighbor's entry instead, which is the shift
   // toward the tail on a push; on a pop every cell takes its right neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      logic      left_insert;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = COUNT_BITS'(i) < count_ff;

      if (i == 0) begin : g_head
         assign left_insert = 1'b0;
         assign left_entry  = cmd.new_entry;
      end else begin : g_body
         assign left_insert = insert_here[i-1];
         assign left_entry  = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .is_head     (i == 0),
         .occupied    (occupied),
         .cmd         (cmd),
         .left_insert (left_insert),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .insert_here (insert_here[i]),
         .entry       (entry[i]),
         .entry_next  (entry_next[i])
      );
   end

   // The response reports the head as it stands after the transaction, and
   // zero for the head fields whenever the queue ends up empty.
   always_comb begin
      if (count_in != '0) begin
         rsp_head_data_in     = entry_next[0].data;
         rsp_head_priority_in = entry_next[0].prio;
      end else begin
         rsp_head_data_in     = '0;
         rsp_head_priority_in = '0;
      end
      rsp_popped_data_in = cmd.pop_ok ? entry[0].data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_head_data_ff     <= rsp_head_data_in;
      rsp_head_priority_ff <= rsp_head_priority_in;
      rsp_popped_data_ff   <= rsp_popped_data_in;
      rsp_entry_count_ff   <= count_in;
      rsp_status_ff        <= status_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_head_data     = rsp_head_data_ff;
   assign rsp_head_priority = rsp_head_priority_ff;
   assign rsp_popped_data   = rsp_popped_data_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;
   assign rsp_is_empty      = rsp_entry_count_ff == '0;
   assign rsp_is_full       = rsp_entry_count_ff == FULL_COUNT;
   assign rsp_status        = rsp_status_ff;

endmodule

FILE: hdl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_macros.svh.
`include "sorted_priority_queue_macros.svh"

module spq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_strobe,
   input logic signed [spq_pkg::DATA_BITS-1:0] rsp_head_data,
   input logic [spq_pkg::PRIORITY_BITS-1:0]    rsp_head_priority,
   input logic signed [spq_pkg::DATA_BITS-1:0] rsp_popped_data,
   input logic                                 rsp_is_empty,
   input logic                                 rsp_is_full,
   input logic [spq_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   input logic [1:0]                           rsp_status
);
   import spq_pkg::*;

   // Every accepted transaction gives exactly one response, in the next cycle.
   `SPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, rsp_strobe)
   `SPQ_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !(start && !busy), !rsp_strobe)

   // An empty queue reports a zero head.
   `SPQ_ASSERT_IMPLY(a_empty_head_zero, clock, reset, rsp_strobe && rsp_is_empty,
      rsp_head_data == '0 && rsp_head_priority == '0)

   // A rejected push pops nothing and means the queue is full.
   `SPQ_ASSERT_IMPLY(a_reject_full, clock, reset,
      rsp_strobe && rsp_status == STATUS_PUSH_FULL, rsp_is_full && rsp_popped_data == '0)

   // The entry count moves by at most one between back-to-back responses.
   `SPQ_ASSERT_IMPLY(a_count_step, clock, reset, rsp_strobe && $past(rsp_strobe),
      rsp_entry_count == $past(rsp_entry_count) ||
      rsp_entry_count == $past(rsp_entry_count) + COUNT_BITS'(1) ||
      rsp_entry_count == $past(rsp_entry_count) - COUNT_BITS'(1))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the sorted priority queue.
// Depends on spq_pkg and the sorted_priority_queue top level only.
`timescale 1ns / 1ps

module tb_top;
   import spq_pkg::*;

   // A cycle with no accepted transaction on either side counts toward this
   // limit. The block takes one transaction per cycle and answers in the next,
   // so a long quiet stretch can only mean the block has hung.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 4;

   // One expected response, held field by field at the block's widths.
   typedef struct packed {
      logic signed [DATA_BITS-1:0] head_data;
      logic [PRIORITY_BITS-1:0]    head_prio;
      logic signed [DATA_BITS-1:0] popped_data;
      logic                        is_empty;
      logic                        is_full;
      logic [COUNT_BITS-1:0]       count;
      status_type                  status;
   } queue_response_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_kind;
   logic signed [DATA_BITS-1:0] req_data_value;
   logic [PRIORITY_BITS-1:0]    req_priority_level;
   logic                        rsp_strobe;
   logic signed [DATA_BITS-1:0] rsp_head_data;
   logic [PRIORITY_BITS-1:0]    rsp_head_priority;
   logic signed [DATA_BITS-1:0] rsp_popped_data;
   logic                        rsp_is_empty;
   logic                        rsp_is_full;
   logic [COUNT_BITS-1:0]       rsp_entry_count;
   logic [1:0]                  rsp_status;

   // Shadow copy of the queue contents, kept in service order with the head
   // at index zero. Only entries below shadow_count are ever read.
   logic signed [DATA_BITS-1:0] shadow_data [CAPACITY];
   logic [PRIORITY_BITS-1:0]    shadow_prio [CAPACITY];
   int                          shadow_count;

   queue_response_type expected_responses[$];
   int                 mismatch_count;
   int                 quiet_cycles;
   int                 sender_idle_pct;

   sorted_priority_queue uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_data_value     (req_data_value),
      .req_priority_level (req_priority_level),
      .rsp_strobe         (rsp_strobe),
      .rsp_head_data      (rsp_head_data),
      .rsp_head_priority  (rsp_head_priority),
      .rsp_popped_data    (rsp_popped_data),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one push or pop to the shadow queue and returns the response the
   // block should give for it. A push goes ahead of the head only when the
   // head's priority is strictly greater; otherwise it goes ahead of the
   // first later entry whose priority is greater than or equal to its own,
   // which puts a new entry behind the head but ahead of its equals.
   function automatic queue_response_type predict_queue_op(kind_type op,
         logic signed [DATA_BITS-1:0] value, logic [PRIORITY_BITS-1:0] level);
      queue_response_type r;
      int pos;
      r = '0;
      r.status = STATUS_DONE;
      if (op == KIND_PUSH) begin
         if (shadow_count >= CAPACITY) begin
            r.status = STATUS_PUSH_FULL;
         end else begin
            if (shadow_count == 0 || shadow_prio[0] > level) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < shadow_count && shadow_prio[pos] < level)
                  pos++;
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_data[i] = shadow_data[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_data[pos] = value;
            shadow_prio[pos] = level;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = STATUS_POP_EMPTY;
         end else begin
            r.popped_data = shadow_data[0];
            for (int i = 1; i < shadow_count; i++) begin
               shadow_data[i-1] = shadow_data[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      // An empty queue shows zero for the head fields.
      if (shadow_count != 0) begin
         r.head_data = shadow_data[0];
         r.head_prio = shadow_prio[0];
      end
      r.is_empty = (shadow_count == 0);
      r.is_full  = (shadow_count >= CAPACITY);
      r.count    = COUNT_BITS'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR at %0d ns: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Everything is sampled at the rising edge, while inputs only move at the
   // falling edge, so the values read here are the ones the block saw. The
   // response to a transaction arrives in the cycle after it is accepted, so the
   // check of a response always comes before the prediction it could meet.
   always @(posedge clock) begin : response_check
      queue_response_type want;
      logic               taken;
      taken = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            taken = 1'b1;
            if (expected_responses.size() == 0) begin
               report_mismatch("response with none outstanding, status",
                               64'(rsp_status), 64'(0));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_head_data !== want.head_data)
                  report_mismatch("head_data", 64'(rsp_head_data), 64'(want.head_data));
               if (rsp_head_priority !== want.head_prio)
                  report_mismatch("head_priority", 64'(rsp_head_priority),
                                  64'(want.head_prio));
               if (rsp_popped_data !== want.popped_data)
                  report_mismatch("popped_data", 64'(rsp_popped_data),
                                  64'(want.popped_data));
               if (rsp_is_empty !== want.is_empty)
                  report_mismatch("is_empty", 64'(rsp_is_empty), 64'(want.is_empty));
               if (rsp_is_full !== want.is_full)
                  report_mismatch("is_full", 64'(rsp_is_full), 64'(want.is_full));
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", 64'(rsp_entry_count), 64'(want.count));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
            end
         end
         if (start && !busy) begin
            taken = 1'b1;
            expected_responses.push_back(predict_queue_op(kind_type'(req_kind),
                                                          req_data_value,
                                                          req_priority_level));
         end
      end
      quiet_cycles = taken ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("sorted_priority_queue: mismatch");
         $finish;
      end
   end

   // Sends one transaction. It is entered and left at a falling edge. Before
   // the request the sender may sit idle for a random number of cycles; start
   // is assigned once per falling edge, so a back-to-back request simply
   // keeps it high.
   task automatic send_op(kind_type op, logic signed [DATA_BITS-1:0] value,
                          logic [PRIORITY_BITS-1:0] level);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start              <= 1'b1;
      req_kind           <= op;
      req_data_value     <= value;
      req_priority_level <= level;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   // A pop from an empty queue is rejected and leaves the head fields zero.
   task automatic test_pop_empty();
      send_op(KIND_POP, 32'sd0, '0);
   endtask

   // Payload and priority extremes; also checks that an entry only goes ahead
   // of the head when the head's priority is strictly greater, and that an
   // entry equal to the tail goes ahead of it.
   task automatic test_push_extremes();
      send_op(KIND_PUSH, 32'sh8000_0000, 16'hFFFF);
      send_op(KIND_PUSH, 32'sh7FFF_FFFF, 16'h0000);
      send_op(KIND_PUSH, 32'sd0, 16'h0000);
      send_op(KIND_PUSH, -32'sd1, 16'hFFFF);
      send_op(KIND_POP, 32'sh5555_5555, 16'h1234);
   endtask

   // Several entries sharing the head's priority: each new one lands just
   // behind the head, ahead of the earlier equals.
   task automatic test_equal_priorities();
      send_op(KIND_PUSH, 32'sh0000_0011, 16'h0000);
      send_op(KIND_PUSH, 32'sh0000_0022, 16'h0000);
      send_op(KIND_PUSH, 32'sh0000_0033, 16'h0000);
      send_op(KIND_POP, 32'sd0, '0);
   endtask

   // Fills the queue, tries one push too many and takes one entry back out.
   task automatic test_full_queue();
      while (shadow_count < CAPACITY)
         send_op(KIND_PUSH, $urandom, PRIORITY_BITS'($urandom_range(16'hFFFF)));
      send_op(KIND_PUSH, 32'sh1357_9BDF, 16'h0001);
      send_op(KIND_POP, 32'sd0, '0);
   endtask

   // Random traffic in bursts. A burst leans toward pushes, toward pops or
   // neither, so that the queue swings between full and empty; its priorities
   // come either from the full range, from a tiny range full of ties, or from
   // the two extremes.
   task automatic test_random_traffic(int items, int idle_pct);
      int       sent;
      int       burst_len;
      int       push_pct;
      int       prio_mode;
      kind_type op;
      logic [PRIORITY_BITS-1:0] level;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < items) begin
         burst_len = $urandom_range(40, 8);
         case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 25;
            default: push_pct = 50;
         endcase
         prio_mode = $urandom_range(2);
         repeat (burst_len) begin
            op = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
            case (prio_mode)
               0:       level = PRIORITY_BITS'($urandom_range(16'hFFFF));
               1:       level = PRIORITY_BITS'($urandom_range(3));
               default: level = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            send_op(op, $urandom, level);
            sent++;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_kind           = KIND_PUSH;
      req_data_value     = '0;
      req_priority_level = '0;
      shadow_count       = 0;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      sender_idle_pct    = 0;
      // Synchronous reset, released at a falling edge.
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_pop_empty();
      test_push_extremes();
      test_equal_priorities();
      test_full_queue();
      test_random_traffic(530, 37);
      test_random_traffic(530, 63);
      test_random_traffic(530, 0);

      // Let the last response come back; the watchdog covers a hang here.
      start <= 1'b0;
      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("sorted_priority_queue: match");
      else
         $display("sorted_priority_queue: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
tb/tb_top.sv
